// ===== design/fr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembler package
// Shared constants, operation and status codes, and the structs passed
// between the control, queue and memory parts of the reassembler.
// ----------------------------------------------------------------------------
package fr_pkg;

   localparam int MESSAGE_DEPTH = 65536;
   localparam int ADDR_WIDTH    = $clog2(MESSAGE_DEPTH);
   localparam int COUNT_WIDTH   = 16;
   localparam int GEN_LEN_BITS  = 5;
   localparam int BYTE_BITS     = 8;

   localparam logic [COUNT_WIDTH:0] DEPTH_LIMIT = (COUNT_WIDTH + 1)'(MESSAGE_DEPTH);

   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_EMPTY   = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_RELEASE = 2'd3;

   localparam logic [2:0] ST_NEED_MORE = 3'd0;
   localparam logic [2:0] ST_COMPLETE  = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_RESERVED  = 3'd4;
   localparam logic [2:0] ST_STRAY     = 3'd5;
   localparam logic [2:0] ST_OVERFLOW  = 3'd6;
   localparam logic [2:0] ST_ZERO      = 3'd7;
   localparam logic [2:0] ST_NONE      = 3'd0;

   localparam logic [1:0] HK_GENERAL  = 2'd0;
   localparam logic [1:0] HK_EXT13    = 2'd1;
   localparam logic [1:0] HK_EXT16    = 2'd2;
   localparam logic [1:0] HK_CONT     = 2'd3;

   localparam logic [1:0] POS_IDLE    = 2'd0;
   localparam logic [1:0] POS_HDR2    = 2'd1;
   localparam logic [1:0] POS_HDR3    = 2'd2;
   localparam logic [1:0] POS_PAYLOAD = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_REPLY  = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [2:0]             status;
      logic                   read_valid;
      logic [COUNT_WIDTH-1:0] stored_length;
   } result_type;

   typedef struct packed {
      logic                   kind;
      logic [2:0]             status;
      logic [BYTE_BITS-1:0]   read_data;
      logic                   read_valid;
      logic [COUNT_WIDTH-1:0] stored_length;
   } rsp_item_type;

   typedef struct packed {
      logic                  we;
      logic [ADDR_WIDTH-1:0] addr;
      logic [BYTE_BITS-1:0]  data;
   } ram_wr_type;

   typedef struct packed {
      logic                  re;
      logic [ADDR_WIDTH-1:0] addr;
   } ram_rd_type;

endpackage

// ===== design/fr_channels.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembler channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
interface fr_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     op;
   logic [fr_pkg::BYTE_BITS-1:0]   data_byte;
   logic                           first_of_packet;
   logic                           last_of_packet;
   logic [fr_pkg::COUNT_WIDTH-1:0] read_index;

   modport source (output valid, output op, output data_byte, output first_of_packet,
                   output last_of_packet, output read_index, input ready);
   modport sink (input valid, input op, input data_byte, input first_of_packet,
                 input last_of_packet, input read_index, output ready);
endinterface

interface fr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [2:0]                     status;
   logic [fr_pkg::BYTE_BITS-1:0]   read_data;
   logic                           read_valid;
   logic [fr_pkg::COUNT_WIDTH-1:0] stored_length;

   modport source (output valid, output kind, output status, output read_data,
                   output read_valid, output stored_length, input ready);
   modport sink (input valid, input kind, input status, input read_data,
                 input read_valid, input stored_length, output ready);
endinterface

// ===== design/fr_ram.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembler RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/fr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembler control
// Header decoding, length and count bookkeeping, packet status, and the
// write and read commands for the message store.
// ----------------------------------------------------------------------------
module fr_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [1:0]                     op,
   input  logic [fr_pkg::BYTE_BITS-1:0]   data_byte,
   input  logic                           first_of_packet,
   input  logic                           last_of_packet,
   input  logic [fr_pkg::COUNT_WIDTH-1:0] read_index,
   output logic                           res_valid,
   output fr_pkg::result_type             res,
   output fr_pkg::ram_wr_type             ram_wr,
   output fr_pkg::ram_rd_type             ram_rd
);

   logic [fr_pkg::COUNT_WIDTH-1:0] stored_ff, stored_in;
   logic [fr_pkg::COUNT_WIDTH-1:0] remain_ff, remain_in;
   logic                           inprog_ff, inprog_in;
   logic [1:0]                     hkind_ff, hkind_in;
   logic [1:0]                     pos_ff, pos_in;
   logic [2:0]                     perr_ff, perr_in;
   logic [fr_pkg::BYTE_BITS-1:0]   lhigh_ff, lhigh_in;

   logic                           len_load;
   logic [fr_pkg::COUNT_WIDTH-1:0] len_val;
   logic                           clear_now;

   always_comb begin
      stored_in = stored_ff;
      remain_in = remain_ff;
      inprog_in = inprog_ff;
      hkind_in  = hkind_ff;
      pos_in    = pos_ff;
      perr_in   = perr_ff;
      lhigh_in  = lhigh_ff;
      len_load  = 1'b0;
      len_val   = '0;
      clear_now = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      ram_wr    = '0;
      ram_rd    = '0;
      ram_wr.addr = stored_ff[fr_pkg::ADDR_WIDTH-1:0];
      ram_wr.data = data_byte;
      ram_rd.addr = read_index[fr_pkg::ADDR_WIDTH-1:0];

      unique case (op)
         fr_pkg::OP_EMPTY: begin
            clear_now = 1'b1;
            res_valid = 1'b1;
            res.kind = fr_pkg::KIND_STATUS;
            res.status = fr_pkg::ST_EMPTY;
         end
         fr_pkg::OP_READ: begin
            res_valid = 1'b1;
            res.kind = fr_pkg::KIND_REPLY;
            res.stored_length = stored_ff;
            res.read_valid = (read_index < stored_ff) &&
                             ({1'b0, read_index} < fr_pkg::DEPTH_LIMIT);
            ram_rd.re = res.read_valid;
         end
         fr_pkg::OP_RELEASE: begin
            clear_now = 1'b1;
            res_valid = 1'b1;
            res.kind = fr_pkg::KIND_REPLY;
            res.stored_length = stored_ff;
         end
         default: begin
            if (first_of_packet || pos_ff == fr_pkg::POS_IDLE) begin
               perr_in = fr_pkg::ST_NONE;
               if (data_byte[fr_pkg::BYTE_BITS-1]) begin
                  hkind_in = fr_pkg::HK_CONT;
                  pos_in = fr_pkg::POS_PAYLOAD;
                  if (!inprog_ff) begin
                     perr_in = fr_pkg::ST_STRAY;
                  end
               end else begin
                  stored_in = '0;
                  hkind_in = data_byte[6:5];
                  unique case (data_byte[6:5])
                     fr_pkg::HK_GENERAL: begin
                        len_load = 1'b1;
                        len_val = fr_pkg::COUNT_WIDTH'(data_byte[fr_pkg::GEN_LEN_BITS-1:0]);
                     end
                     fr_pkg::HK_EXT13: begin
                        lhigh_in = fr_pkg::BYTE_BITS'(data_byte[fr_pkg::GEN_LEN_BITS-1:0]);
                        pos_in = fr_pkg::POS_HDR2;
                     end
                     fr_pkg::HK_EXT16: begin
                        pos_in = fr_pkg::POS_HDR2;
                     end
                     default: begin
                        pos_in = fr_pkg::POS_PAYLOAD;
                        perr_in = fr_pkg::ST_RESERVED;
                     end
                  endcase
               end
            end else if (perr_ff == fr_pkg::ST_NONE) begin
               unique case (pos_ff)
                  fr_pkg::POS_HDR2: begin
                     if (hkind_ff == fr_pkg::HK_EXT13) begin
                        len_load = 1'b1;
                        len_val = {lhigh_ff, data_byte};
                     end else begin
                        lhigh_in = data_byte;
                        pos_in = fr_pkg::POS_HDR3;
                     end
                  end
                  fr_pkg::POS_HDR3: begin
                     len_load = 1'b1;
                     len_val = {lhigh_ff, data_byte};
                  end
                  default: begin
                     if (remain_ff == '0 || {1'b0, stored_ff} >= fr_pkg::DEPTH_LIMIT) begin
                        perr_in = fr_pkg::ST_OVERFLOW;
                     end else begin
                        ram_wr.we = 1'b1;
                        stored_in = stored_ff + 1'b1;
                        remain_in = remain_ff - 1'b1;
                     end
                  end
               endcase
            end

            if (len_load) begin
               pos_in = fr_pkg::POS_PAYLOAD;
               if (len_val == '0) begin
                  perr_in = fr_pkg::ST_ZERO;
               end else if ({1'b0, len_val} > fr_pkg::DEPTH_LIMIT) begin
                  perr_in = fr_pkg::ST_OVERFLOW;
               end else begin
                  remain_in = len_val;
                  inprog_in = 1'b1;
               end
            end

            if (last_of_packet) begin
               res_valid = 1'b1;
               res.kind = fr_pkg::KIND_STATUS;
               if (perr_in == fr_pkg::ST_NONE && pos_in != fr_pkg::POS_PAYLOAD) begin
                  perr_in = fr_pkg::ST_TRUNCATED;
               end
               if (perr_in != fr_pkg::ST_NONE) begin
                  res.status = perr_in;
                  clear_now = 1'b1;
               end else if (remain_in == '0) begin
                  inprog_in = 1'b0;
                  res.status = fr_pkg::ST_COMPLETE;
               end else begin
                  res.status = fr_pkg::ST_NEED_MORE;
               end
               pos_in = fr_pkg::POS_IDLE;
               res.stored_length = clear_now ? '0 : stored_in;
            end
         end
      endcase

      if (clear_now) begin
         stored_in = '0;
         remain_in = '0;
         inprog_in = 1'b0;
         hkind_in  = fr_pkg::HK_GENERAL;
         pos_in    = fr_pkg::POS_IDLE;
         perr_in   = fr_pkg::ST_NONE;
         lhigh_in  = '0;
      end

      if (!accept) begin
         res_valid = 1'b0;
         ram_wr.we = 1'b0;
         ram_rd.re = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff <= '0;
         remain_ff <= '0;
         inprog_ff <= 1'b0;
         hkind_ff  <= fr_pkg::HK_GENERAL;
         pos_ff    <= fr_pkg::POS_IDLE;
         perr_ff   <= fr_pkg::ST_NONE;
         lhigh_ff  <= '0;
      end else if (accept) begin
         stored_ff <= stored_in;
         remain_ff <= remain_in;
         inprog_ff <= inprog_in;
         hkind_ff  <= hkind_in;
         pos_ff    <= pos_in;
         perr_ff   <= perr_in;
         lhigh_ff  <= lhigh_in;
      end
   end

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr.we |-> ({1'b0, stored_ff} < fr_pkg::DEPTH_LIMIT && remain_ff != '0))
      else $error("store write with no room left");

   a_write_advances: assert property (@(posedge clock) disable iff (reset)
      ram_wr.we |=> stored_ff == $past(stored_ff) + 1'b1)
      else $error("store write did not advance the stored count");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && op == fr_pkg::OP_BYTE && last_of_packet) |=> pos_ff == fr_pkg::POS_IDLE)
      else $error("packet end left a packet open");

endmodule

// ===== design/fr_out_queue.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembler result queue
// Holds a result for the store read latency, merges in the read data, and
// buffers results in two entries toward the result channel.
// ----------------------------------------------------------------------------
module fr_out_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  fr_pkg::result_type           in_res,
   input  logic [fr_pkg::BYTE_BITS-1:0] rdata,
   output logic                         space,
   fr_rsp_if.source                     rsp_chan
);

   logic                 s1_valid_ff, s1_valid_in;
   fr_pkg::result_type   s1_res_ff;
   fr_pkg::rsp_item_type q_ff [2];
   fr_pkg::rsp_item_type q_item;
   fr_pkg::rsp_item_type head_item;
   logic                 head_ff;
   logic [1:0]           count_ff, count_in;
   logic                 push;
   logic                 pop;
   logic                 tail;

   assign pop  = (count_ff != 2'd0) && rsp_chan.ready;
   assign push = s1_valid_ff && (count_ff != 2'd2);
   assign tail = head_ff ^ count_ff[0];
   assign space = !(s1_valid_ff && count_ff == 2'd2);
   assign s1_valid_in = in_valid || (s1_valid_ff && !push);

   always_comb begin
      q_item.kind          = s1_res_ff.kind;
      q_item.status        = s1_res_ff.status;
      q_item.read_valid    = s1_res_ff.read_valid;
      q_item.stored_length = s1_res_ff.stored_length;
      q_item.read_data     = s1_res_ff.read_valid ? rdata : '0;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff <= 2'd0;
         head_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         count_ff <= count_in;
         if (pop) begin
            head_ff <= !head_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_res_ff <= in_res;
      end
      if (push) begin
         q_ff[tail] <= q_item;
      end
   end

   assign head_item              = q_ff[head_ff];
   assign rsp_chan.valid         = count_ff != 2'd0;
   assign rsp_chan.kind          = head_item.kind;
   assign rsp_chan.status        = head_item.status;
   assign rsp_chan.read_data     = head_item.read_data;
   assign rsp_chan.read_valid    = head_item.read_valid;
   assign rsp_chan.stored_length = head_item.stored_length;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !push) |=> (s1_valid_ff && $stable(s1_res_ff)))
      else $error("held result changed while the queue was full");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && count_ff == 2'd2) |-> !in_valid)
      else $error("request taken with no room for its result");

endmodule

// ===== design/fragment_reassembler.sv =====
// ----------------------------------------------------------------------------
// Fragment reassembler
// Rebuilds a length-prefixed message from byte-wide packets into a message
// store, and answers status, read and release requests.
//
//   Channel   Direction  Handshake     Contents
//   req_chan  in         valid/ready   op, data_byte, first/last flags, read_index
//   rsp_chan  out        valid/ready   kind, status, read_data, read_valid, length
//
// One request is taken every cycle while req_chan.ready is high; each result
// is registered together with its store read, then buffered in the queue.
// Reset is synchronous and clears all counters; the store itself is not
// cleared, since only written positions are ever read.
// Up to three results are buffered; req_chan.ready drops only when all three
// places are taken.
// ----------------------------------------------------------------------------
module fragment_reassembler (
   input  logic      clock,
   input  logic      reset,
   fr_req_if.sink    req_chan,
   fr_rsp_if.source  rsp_chan
);

   logic                         accept;
   logic                         space;
   logic                         res_valid;
   fr_pkg::result_type           res;
   fr_pkg::ram_wr_type           ram_wr;
   fr_pkg::ram_rd_type           ram_rd;
   logic [fr_pkg::BYTE_BITS-1:0] rdata;

   assign req_chan.ready = space;
   assign accept = req_chan.valid && space;

   fr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .op              (req_chan.op),
      .data_byte       (req_chan.data_byte),
      .first_of_packet (req_chan.first_of_packet),
      .last_of_packet  (req_chan.last_of_packet),
      .read_index      (req_chan.read_index),
      .res_valid       (res_valid),
      .res             (res),
      .ram_wr          (ram_wr),
      .ram_rd          (ram_rd)
   );

   fr_ram #(
      .WIDTH (fr_pkg::BYTE_BITS),
      .DEPTH (fr_pkg::MESSAGE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_wr.we),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .re    (ram_rd.re),
      .raddr (ram_rd.addr),
      .rdata (rdata)
   );

   fr_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_res   (res),
      .rdata    (rdata),
      .space    (space),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== bench/tb_fragment_reassembler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fragment reassembler testbench
// Drives directed and random packet streams, reads and releases into the
// reassembler. A built-in model of the message store and header parser
// predicts each result not given in the directed rows; all are checked in order.
// The sender idles and the receiver stalls at varying rates across phases.
// ----------------------------------------------------------------------------
module tb_fragment_reassembler;

   typedef struct packed {
      logic [1:0]                     op;
      logic [fr_pkg::BYTE_BITS-1:0]   data_byte;
      logic                           first_of_packet;
      logic                           last_of_packet;
      logic [fr_pkg::COUNT_WIDTH-1:0] read_index;
   } request_type;

   typedef struct packed {
      request_type          req;
      logic                 typed;
      fr_pkg::rsp_item_type rsp;
   } stimulus_row_type;

   typedef logic [7:0] byte_queue_type[$];

   logic clock;
   logic reset;

   fr_req_if req_chan ();
   fr_rsp_if rsp_chan ();

   fragment_reassembler u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [7:0]       msg_bytes [0:fr_pkg::MESSAGE_DEPTH-1];
   logic [16:0]      held_count;
   logic [15:0]      left_count;
   logic             assembling;
   logic [1:0]       hdr_kind;
   logic [1:0]       hdr_pos;
   logic [2:0]       err_code;
   logic [7:0]       len_hi;

   fr_pkg::rsp_item_type awaited_results[$];
   stimulus_row_type     rows[$];
   int               fail_count = 0;
   int               sent_count = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               hold_req = 0;
   int               hold_seen = 0;
   int               hold_left = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void add_row(input stimulus_row_type s);
      rows.insert(rows.size(), s);
   endfunction

   function automatic void clear_message();
      held_count = '0;
      left_count = '0;
      assembling = 1'b0;
      hdr_kind   = fr_pkg::HK_GENERAL;
      hdr_pos    = fr_pkg::POS_IDLE;
      err_code   = fr_pkg::ST_NONE;
      len_hi     = '0;
   endfunction

   function automatic void take_length(input logic [15:0] len);
      hdr_pos = fr_pkg::POS_PAYLOAD;
      if (len == 16'd0) begin
         err_code = fr_pkg::ST_ZERO;
      end else if ({1'b0, len} > fr_pkg::DEPTH_LIMIT) begin
         err_code = fr_pkg::ST_OVERFLOW;
      end else begin
         left_count = len;
         assembling = 1'b1;
      end
   endfunction

   // Advances the message state by one request; returns 1 when it yields a result.
   function automatic logic reassembly_outcome(input request_type r,
                                               output fr_pkg::rsp_item_type res);
      logic [7:0] b;
      b = r.data_byte;
      res = '0;
      case (r.op)
         fr_pkg::OP_EMPTY: begin
            clear_message();
            res.status = fr_pkg::ST_EMPTY;
            return 1'b1;
         end
         fr_pkg::OP_READ: begin
            res.kind = fr_pkg::KIND_REPLY;
            if ({1'b0, r.read_index} < held_count) begin
               res.read_data  = msg_bytes[r.read_index];
               res.read_valid = 1'b1;
            end
            res.stored_length = held_count[15:0];
            return 1'b1;
         end
         fr_pkg::OP_RELEASE: begin
            res.kind = fr_pkg::KIND_REPLY;
            res.stored_length = held_count[15:0];
            clear_message();
            return 1'b1;
         end
         default: begin
         end
      endcase

      if (r.first_of_packet || hdr_pos == fr_pkg::POS_IDLE) begin
         err_code = fr_pkg::ST_NONE;
         if (b[7]) begin
            hdr_kind = fr_pkg::HK_CONT;
            hdr_pos  = fr_pkg::POS_PAYLOAD;
            if (!assembling) err_code = fr_pkg::ST_STRAY;
         end else begin
            held_count = '0;
            hdr_kind   = b[6:5];
            case (hdr_kind)
               fr_pkg::HK_GENERAL: take_length({11'd0, b[4:0]});
               fr_pkg::HK_EXT13: begin
                  len_hi  = {3'd0, b[4:0]};
                  hdr_pos = fr_pkg::POS_HDR2;
               end
               fr_pkg::HK_EXT16: hdr_pos = fr_pkg::POS_HDR2;
               default: begin
                  hdr_pos  = fr_pkg::POS_PAYLOAD;
                  err_code = fr_pkg::ST_RESERVED;
               end
            endcase
         end
      end else if (err_code == fr_pkg::ST_NONE) begin
         case (hdr_pos)
            fr_pkg::POS_HDR2: begin
               if (hdr_kind == fr_pkg::HK_EXT13) begin
                  take_length({len_hi, b});
               end else begin
                  len_hi  = b;
                  hdr_pos = fr_pkg::POS_HDR3;
               end
            end
            fr_pkg::POS_HDR3: take_length({len_hi, b});
            default: begin
               if (left_count == 16'd0 || held_count >= fr_pkg::DEPTH_LIMIT) begin
                  err_code = fr_pkg::ST_OVERFLOW;
               end else begin
                  msg_bytes[held_count[15:0]] = b;
                  held_count = held_count + 17'd1;
                  left_count = left_count - 16'd1;
               end
            end
         endcase
      end

      if (!r.last_of_packet) return 1'b0;

      if (err_code == fr_pkg::ST_NONE && hdr_pos != fr_pkg::POS_PAYLOAD) begin
         err_code = fr_pkg::ST_TRUNCATED;
      end
      res.kind = fr_pkg::KIND_STATUS;
      if (err_code != fr_pkg::ST_NONE) begin
         res.status = err_code;
         clear_message();
      end else if (left_count == 16'd0) begin
         assembling = 1'b0;
         res.status = fr_pkg::ST_COMPLETE;
      end else begin
         res.status = fr_pkg::ST_NEED_MORE;
      end
      hdr_pos = fr_pkg::POS_IDLE;
      res.stored_length = held_count[15:0];
      return 1'b1;
   endfunction

   function automatic request_type req_of(input logic [1:0] op, input logic [7:0] data,
                                          input logic first, input logic last,
                                          input logic [15:0] idx);
      request_type r;
      r.op = op;
      r.data_byte = data;
      r.first_of_packet = first;
      r.last_of_packet = last;
      r.read_index = idx;
      return r;
   endfunction

   function automatic request_type byte_req(input logic [7:0] data, input logic first,
                                            input logic last);
      return req_of(fr_pkg::OP_BYTE, data, first, last, 16'd0);
   endfunction

   function automatic stimulus_row_type plain(input request_type r);
      stimulus_row_type s;
      s.req = r;
      s.typed = 1'b0;
      s.rsp = '0;
      return s;
   endfunction

   function automatic stimulus_row_type checked(input request_type r, input logic kind,
                                                input logic [2:0] status,
                                                input logic [15:0] len);
      stimulus_row_type s;
      s.req = r;
      s.typed = 1'b1;
      s.rsp = '0;
      s.rsp.kind = kind;
      s.rsp.status = status;
      s.rsp.stored_length = len;
      return s;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_request(input request_type r, input logic typed,
                               input fr_pkg::rsp_item_type typed_rsp);
      fr_pkg::rsp_item_type predicted;
      logic                 has_result;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.op              <= r.op;
      req_chan.data_byte       <= r.data_byte;
      req_chan.first_of_packet <= r.first_of_packet;
      req_chan.last_of_packet  <= r.last_of_packet;
      req_chan.read_index      <= r.read_index;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      has_result = reassembly_outcome(r, predicted);
      if (has_result) begin
         awaited_results.insert(awaited_results.size(), typed ? typed_rsp : predicted);
      end
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_packet(input byte_queue_type bytes);
      int   i;
      logic first;
      logic last;
      for (i = 0; i < bytes.size(); i++) begin
         first = (i == 0) && ($urandom_range(29) != 0);
         last  = (i == bytes.size() - 1) && ($urandom_range(39) != 0);
         send_request(byte_req(bytes[i], first, last), 1'b0, '0);
      end
   endtask

   task automatic send_read();
      logic [15:0] idx;
      if (held_count != 0 && $urandom_range(3) != 0) idx = 16'($urandom_range(held_count - 1));
      else idx = 16'($urandom);
      send_request(req_of(fr_pkg::OP_READ, 8'($urandom), 1'($urandom), 1'($urandom), idx),
                   1'b0, '0);
   endtask

   task automatic send_message();
      int             total;
      int             sent;
      int             chunk;
      logic [15:0]    dlen;
      byte_queue_type pkt;
      pkt = {};
      case ($urandom_range(2))
         0: begin
            dlen = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(31, 1));
            pkt = {pkt, {3'b000, dlen[4:0]}};
         end
         1: begin
            dlen = ($urandom_range(7) == 0) ? 16'($urandom_range(8191))
                                            : 16'($urandom_range(80, 1));
            pkt = {pkt, {3'b001, dlen[12:8]}};
            pkt = {pkt, dlen[7:0]};
         end
         default: begin
            dlen = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(80, 1));
            pkt = {pkt, {3'b010, 5'($urandom)}};
            pkt = {pkt, dlen[15:8]};
            pkt = {pkt, dlen[7:0]};
         end
      endcase
      total = (dlen > 120) ? $urandom_range(120) : int'(dlen);
      if (dlen <= 120 && $urandom_range(9) == 0) total = dlen + 1;
      chunk = $urandom_range(total < 12 ? total : 12);
      repeat (chunk) pkt = {pkt, 8'($urandom)};
      sent = chunk;
      send_packet(pkt);
      while (sent < total && $urandom_range(15) != 0) begin
         pkt = {};
         pkt = {pkt, {1'b1, 7'($urandom)}};
         chunk = $urandom_range(total - sent < 12 ? total - sent : 12, 1);
         repeat (chunk) pkt = {pkt, 8'($urandom)};
         sent += chunk;
         send_packet(pkt);
      end
      repeat ($urandom_range(3)) send_read();
      case ($urandom_range(5))
         0, 1: send_request(req_of(fr_pkg::OP_RELEASE, 8'($urandom), 1'($urandom),
                                   1'($urandom), 16'($urandom)), 1'b0, '0);
         2: send_request(req_of(fr_pkg::OP_EMPTY, 8'($urandom), 1'($urandom),
                                1'($urandom), 16'($urandom)), 1'b0, '0);
         default: begin
         end
      endcase
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input int idle, input int stall, input int target);
      send_idle_pct = idle;
      recv_stall_pct <= stall;
      while (sent_count < target) begin
         if ($urandom_range(99) < 85) begin
            send_message();
         end else begin
            send_request(req_of(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                                16'($urandom)), 1'b0, '0);
         end
      end
      drain();
   endtask

   always @(negedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : result_monitor
      fr_pkg::rsp_item_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (awaited_results.size() == 0) begin
            $error("result arrived with no request waiting for one");
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_chan.kind));
            check_field("status", 16'(want.status), 16'(rsp_chan.status));
            check_field("read_data", 16'(want.read_data), 16'(rsp_chan.read_data));
            check_field("read_valid", 16'(want.read_valid), 16'(rsp_chan.read_valid));
            check_field("stored_length", want.stored_length, rsp_chan.stored_length);
         end
      end
   end

   initial begin
      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.op              = fr_pkg::OP_BYTE;
      req_chan.data_byte       = '0;
      req_chan.first_of_packet = 1'b0;
      req_chan.last_of_packet  = 1'b0;
      req_chan.read_index      = '0;
      rsp_chan.ready           = 1'b0;
      clear_message();

      add_row(checked(req_of(fr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'h0000),
                      fr_pkg::KIND_REPLY, fr_pkg::ST_NONE, 16'd0));
      add_row(checked(req_of(fr_pkg::OP_READ, 8'hFF, 1'b1, 1'b1, 16'hFFFF),
                      fr_pkg::KIND_REPLY, fr_pkg::ST_NONE, 16'd0));
      add_row(checked(req_of(fr_pkg::OP_RELEASE, 8'h00, 1'b0, 1'b0, 16'h0000),
                      fr_pkg::KIND_REPLY, fr_pkg::ST_NONE, 16'd0));
      add_row(checked(req_of(fr_pkg::OP_EMPTY, 8'h00, 1'b0, 1'b0, 16'h0000),
                      fr_pkg::KIND_STATUS, fr_pkg::ST_EMPTY, 16'd0));
      add_row(checked(byte_req(8'h00, 1'b1, 1'b1), fr_pkg::KIND_STATUS,
                      fr_pkg::ST_ZERO, 16'd0));
      add_row(checked(byte_req(8'h60, 1'b1, 1'b1), fr_pkg::KIND_STATUS,
                      fr_pkg::ST_RESERVED, 16'd0));
      add_row(checked(byte_req(8'hFF, 1'b1, 1'b1), fr_pkg::KIND_STATUS,
                      fr_pkg::ST_STRAY, 16'd0));
      add_row(checked(byte_req(8'h20, 1'b1, 1'b1), fr_pkg::KIND_STATUS,
                      fr_pkg::ST_TRUNCATED, 16'd0));
      add_row(plain(byte_req(8'h40, 1'b1, 1'b0)));
      add_row(checked(byte_req(8'h12, 1'b0, 1'b1), fr_pkg::KIND_STATUS,
                      fr_pkg::ST_TRUNCATED, 16'd0));
      add_row(plain(byte_req(8'h03, 1'b0, 1'b0)));
      add_row(plain(byte_req(8'hFF, 1'b0, 1'b0)));
      add_row(plain(byte_req(8'h00, 1'b0, 1'b1)));
      add_row(plain(byte_req(8'h80, 1'b1, 1'b0)));
      add_row(plain(byte_req(8'hA5, 1'b0, 1'b1)));
      add_row(plain(req_of(fr_pkg::OP_READ, 8'h00, 1'b0, 1'b0, 16'd2)));
      add_row(checked(byte_req(8'h81, 1'b1, 1'b1), fr_pkg::KIND_STATUS,
                      fr_pkg::ST_STRAY, 16'd0));
      add_row(plain(byte_req(8'h3F, 1'b1, 1'b0)));
      add_row(plain(byte_req(8'hFF, 1'b0, 1'b0)));
      add_row(plain(byte_req(8'h5A, 1'b0, 1'b0)));
      add_row(plain(byte_req(8'h41, 1'b1, 1'b0)));
      add_row(plain(byte_req(8'hFF, 1'b0, 1'b0)));
      add_row(plain(byte_req(8'hFF, 1'b0, 1'b0)));
      add_row(plain(byte_req(8'h77, 1'b0, 1'b1)));
      add_row(plain(req_of(fr_pkg::OP_RELEASE, 8'h00, 1'b0, 1'b0, 16'h0000)));
      add_row(plain(byte_req(8'h01, 1'b1, 1'b0)));
      add_row(plain(byte_req(8'h11, 1'b0, 1'b0)));
      add_row(plain(byte_req(8'h22, 1'b0, 1'b0)));
      add_row(checked(byte_req(8'h33, 1'b0, 1'b1), fr_pkg::KIND_STATUS,
                      fr_pkg::ST_OVERFLOW, 16'd0));
      add_row(plain(byte_req(8'h02, 1'b1, 1'b0)));
      add_row(checked(req_of(fr_pkg::OP_EMPTY, 8'h00, 1'b0, 1'b0, 16'h0000),
                      fr_pkg::KIND_STATUS, fr_pkg::ST_EMPTY, 16'd0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);
      drain();

      // The receiver holds off while reads keep coming, so the result buffer fills.
      hold_req <= hold_req + 1;
      repeat (12) send_read();
      run_phase(0, 0, 500);
      run_phase(65, 0, 980);
      run_phase(0, 65, 1460);
      run_phase(24, 24, 1950);

      repeat (10) @(negedge clock);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
